FILE: hw/rtl/utf8_stream_decoder_macros.svh
// assertion helpers shared by the decoder rtl
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// property that must hold at every clock once out of reset
`define UTF8D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define UTF8D_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/utf8d_pkg.sv
package utf8d_pkg;

    // default depth of the job queue between front and back
    localparam int unsigned UTF8D_QUEUE_DEPTH = 4;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [2:0]  ERR_BYTES_USED = 3'd1;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [20:0] code_point;
        logic        malformed;
        logic [2:0]  bytes_used;
        logic        run_last;
        logic        text_done;
    } t_out_item;

    // work for one accepted byte: n_err replacements, then an optional good result
    typedef struct packed {
        logic [2:0]  n_err;
        logic        has_good;
        logic [20:0] good_cp;
        logic [2:0]  good_used;
        logic        text_end;
    } t_job;

endpackage

FILE: hw/rtl/utf8d_byte_if.sv
interface utf8d_byte_if;
    import utf8d_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/utf8d_cp_if.sv
interface utf8d_cp_if;
    import utf8d_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/utf8d_front.sv
`include "utf8_stream_decoder_macros.svh"

module utf8d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    utf8d_byte_if.sink      i_byte,
    input  logic            i_queue_ready,
    output logic            o_push,
    output utf8d_pkg::t_job o_job
);
    import utf8d_pkg::*;

    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

    localparam logic [20:0] MAX_ONE_BYTE   = 21'h00007F;
    localparam logic [20:0] MAX_TWO_BYTE   = 21'h0007FF;
    localparam logic [20:0] MAX_THREE_BYTE = 21'h00FFFF;
    localparam logic [20:0] SCALAR_MAX     = 21'h10FFFF;

    logic [20:0] r_pv, n_pv;
    logic [2:0]  r_exp, n_exp;
    logic [2:0]  r_held, n_held;

    logic        in_acc;
    logic [7:0]  b;
    logic        last;
    logic        is_cont;
    logic        start;
    logic [20:0] ext_pv;
    t_job        job;

    function automatic logic value_ok(input logic [20:0] v, input logic [2:0] len);
        logic ok;
        priority case (len)
            SEQ_TWO:   ok = (v > MAX_ONE_BYTE);
            SEQ_THREE: ok = (v > MAX_TWO_BYTE);
            default:   ok = (v > MAX_THREE_BYTE) && (v <= SCALAR_MAX);
        endcase
        return ok;
    endfunction

    assign b             = i_byte.data.byte_in;
    assign last          = i_byte.data.text_end;
    assign is_cont       = (b[7:6] == 2'b10);
    assign ext_pv        = {r_pv[14:0], b[5:0]};
    assign i_byte.ready  = i_queue_ready;
    assign in_acc        = i_byte.valid && i_queue_ready;

    always_comb begin
        n_pv   = r_pv;
        n_exp  = r_exp;
        n_held = r_held;
        start  = 1'b0;
        job           = '0;
        job.text_end  = last;

        if (r_held != 3'd0) begin
            if (is_cont) begin
                n_pv   = ext_pv;
                n_held = r_held + 3'd1;
                if (n_held >= r_exp) begin
                    if (value_ok(ext_pv, r_exp)) begin
                        job.has_good  = 1'b1;
                        job.good_cp   = ext_pv;
                        job.good_used = r_exp;
                    end else begin
                        job.n_err = n_held;
                    end
                    n_pv   = '0;
                    n_exp  = SEQ_NONE;
                    n_held = 3'd0;
                end
            end else begin
                // broken sequence: one error per held byte, then rescan this byte
                job.n_err = r_held;
                n_pv   = '0;
                n_exp  = SEQ_NONE;
                n_held = 3'd0;
                start  = 1'b1;
            end
        end else begin
            start = 1'b1;
        end

        if (start) begin
            priority if (b[7] == 1'b0) begin
                job.has_good  = 1'b1;
                job.good_cp   = {13'd0, b};
                job.good_used = 3'd1;
            end else if (b[7:5] == 3'b110) begin
                n_pv = {16'd0, b[4:0]}; n_exp = SEQ_TWO; n_held = 3'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_pv = {17'd0, b[3:0]}; n_exp = SEQ_THREE; n_held = 3'd1;
            end else if (b[7:3] == 5'b11110) begin
                n_pv = {18'd0, b[2:0]}; n_exp = SEQ_FOUR; n_held = 3'd1;
            end else begin
                job.n_err = job.n_err + 3'd1;
            end
        end

        // end of text flushes whatever is still open
        if (last && (n_held != 3'd0)) begin
            job.n_err = job.n_err + n_held;
            n_pv   = '0;
            n_exp  = SEQ_NONE;
            n_held = 3'd0;
        end
    end

    assign o_job  = job;
    assign o_push = in_acc && ((job.n_err != 3'd0) || job.has_good);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= '0;
            r_exp  <= SEQ_NONE;
            r_held <= 3'd0;
        end else if (in_acc) begin
            r_pv   <= n_pv;
            r_exp  <= n_exp;
            r_held <= n_held;
        end
    end

    `UTF8D_ASSERT(a_held_bounded, r_held <= r_exp, "front holds more bytes than expected")
    `UTF8D_ASSERT_IMPL(a_open_has_len, r_held != 3'd0, r_exp >= SEQ_TWO, "open sequence too short")

endmodule

FILE: hw/rtl/utf8d_queue.sv
`include "utf8_stream_decoder_macros.svh"

module utf8d_queue #(
    parameter int unsigned DEPTH = utf8d_pkg::UTF8D_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utf8d_pkg::t_job i_push_job,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_avail,
    output utf8d_pkg::t_job o_pop_job
);
    import utf8d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_ready   = (r_count != CNT_W'(DEPTH));
    assign o_avail   = (r_count != '0);
    assign o_pop_job = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        priority case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    `UTF8D_ASSERT(a_count_bounded, r_count <= CNT_W'(DEPTH), "queue count past depth")
    `UTF8D_ASSERT_IMPL(a_no_pop_empty, i_pop, r_count != '0, "pop from empty queue")

endmodule

FILE: hw/rtl/utf8d_back.sv
`include "utf8_stream_decoder_macros.svh"

module utf8d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  utf8d_pkg::t_job i_job,
    output logic            o_pop,
    utf8d_cp_if.source      o_cp
);
    import utf8d_pkg::*;

    logic       r_busy, n_busy;
    t_job       r_job, n_job;
    logic [2:0] r_err_left, n_err_left;

    logic cur_err;
    logic last;
    logic out_acc;
    logic load;

    assign cur_err = (r_err_left != 3'd0);
    assign last    = (r_err_left == 3'd0) || ((r_err_left == 3'd1) && !r_job.has_good);
    assign out_acc = r_busy && o_cp.ready;
    assign load    = i_avail && (!r_busy || (out_acc && last));
    assign o_pop   = load;

    assign o_cp.valid           = r_busy;
    assign o_cp.data.code_point = cur_err ? REPLACEMENT_CP : r_job.good_cp;
    assign o_cp.data.malformed  = cur_err;
    assign o_cp.data.bytes_used = cur_err ? ERR_BYTES_USED : r_job.good_used;
    assign o_cp.data.run_last   = last;
    assign o_cp.data.text_done  = last && r_job.text_end;

    always_comb begin
        n_busy     = r_busy;
        n_job      = r_job;
        n_err_left = r_err_left;
        if (load) begin
            n_busy     = 1'b1;
            n_job      = i_job;
            n_err_left = i_job.n_err;
        end else if (out_acc) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_err_left = r_err_left - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_err_left <= 3'd0;
        end else begin
            r_busy     <= n_busy;
            r_err_left <= n_err_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    `UTF8D_ASSERT_IMPL(a_job_nonempty, r_busy, (r_err_left != 3'd0) || r_job.has_good, "empty job loaded")
    `UTF8D_ASSERT_NEXT(a_run_continues, out_acc && !last, o_cp.valid, "run ended early")

endmodule

FILE: hw/rtl/utf8_stream_decoder.sv
// a byte's job is registered in the job queue, then loaded into the back's output register, which offers its results
// throughput: one byte per cycle while the job queue has room; one result per cycle out
//   while o_cp is ready, so a byte that causes k results gives k result beats (k up to 4)
// the output register and the job queue let input and output stall independently
// reset: synchronous active low, clears decode state, queue and output valid; no clearing pass
module utf8_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = utf8d_pkg::UTF8D_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utf8d_byte_if.sink i_byte,
    utf8d_cp_if.source o_cp
);
    import utf8d_pkg::*;

    // front to queue
    logic push;
    t_job push_job;
    logic queue_ready;

    // queue to back
    logic pop;
    logic avail;
    t_job pop_job;

    // front: takes one byte per beat, tracks the open sequence and
    // turns each byte into a job (errors to flush plus an optional code point)
    utf8d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (i_byte),
        .i_queue_ready (queue_ready),
        .o_push        (push),
        .o_job         (push_job)
    );

    // short job queue, bytes that give no result never enter it
    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_ready    (queue_ready),
        .i_pop      (pop),
        .o_avail    (avail),
        .o_pop_job  (pop_job)
    );

    // back: plays out each job as one result beat per cycle while o_cp is ready, from its
    // output register, marking the last beat of each byte and of the text
    utf8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_job   (pop_job),
        .o_pop   (pop),
        .o_cp    (o_cp)
    );

endmodule
